// ===== src/eiphc_pkg.sv =====
`default_nettype none

package eiphc_pkg;

  // Frame offsets of the fields that are captured, counted from the first byte.
  localparam logic [15:0] OffEtypeHi  = 16'd12;
  localparam logic [15:0] OffEtypeLo  = 16'd13;
  localparam logic [15:0] OffIp       = 16'd14;
  localparam logic [15:0] OffTos      = 16'd15;
  localparam logic [15:0] OffTlenHi   = 16'd16;
  localparam logic [15:0] OffTlenLo   = 16'd17;
  localparam logic [15:0] OffPseudoLen = 16'd18;
  localparam logic [15:0] OffPseudoPrt = 16'd19;
  localparam logic [15:0] OffArpOpHi  = 16'd20;
  localparam logic [15:0] OffArpOpLo  = 16'd21;
  localparam logic [15:0] OffTtl      = 16'd22;
  localparam logic [15:0] OffProto    = 16'd23;
  localparam logic [15:0] OffSegStart = 16'd26;
  localparam logic [15:0] OffL4       = 16'd34;
  localparam logic [15:0] OffPortsEnd = 16'd38;
  localparam logic [15:0] OffSeqEnd   = 16'd46;
  localparam logic [15:0] OffFlags    = 16'd47;
  localparam logic [15:0] OffWinHi    = 16'd48;
  localparam logic [15:0] OffWinLo    = 16'd49;
  localparam logic [15:0] OffLimit    = 16'hffff;

  localparam logic [15:0] EtypeIpv4 = 16'h0800;
  localparam logic [15:0] EtypeArp  = 16'h0806;

  localparam logic [7:0] ProtoIcmp = 8'd1;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;

  localparam logic [3:0] IpVersion4 = 4'd4;

  // A deferred-carry one's complement sum verifies when it is a nonzero
  // multiple of 0xffff; in 17 bits that is one of these two values.
  localparam logic [16:0] SumGoodLo = 17'h0ffff;
  localparam logic [16:0] SumGoodHi = 17'h1fffe;

  typedef enum logic [1:0] {
    FK_OTHER = 2'd0,
    FK_IPV4  = 2'd1,
    FK_ARP   = 2'd2
  } frame_kind_e;

  typedef enum logic [1:0] {
    L4_NONE = 2'd0,
    L4_UDP  = 2'd1,
    L4_TCP  = 2'd2,
    L4_ICMP = 2'd3
  } l4_kind_e;

  typedef struct packed {
    frame_kind_e frame_kind;
    l4_kind_e    l4_kind;
    logic [7:0]  ip_tos;
    logic [7:0]  ip_ttl;
    logic        ip_sum_ok;
    logic [63:0] ip_pair;
    logic [31:0] port_pair;
    logic [63:0] seq_ack_pair;
    logic [2:0]  tcp_flag_bits;
    logic [15:0] tcp_window;
    logic        tcp_sum_ok;
    logic [15:0] aux_code;
  } summary_t;

endpackage

`default_nettype wire

// ===== src/ethernet_ip_header_parser_checker_top.sv =====
`default_nettype none

// Channel   Direction  Handshake                Payload
// in        input      in_valid_i/in_ready_o    frame_byte_i, frame_end_i
// out       output     out_valid_o/out_ready_i  frame_kind_o .. aux_code_o
//
// One byte is taken per cycle unless a last byte is held in the input register. A
// byte passes an input register, and from there it updates the running header
// state; on a frame's last byte the summary is written into the output register.
// Reset clears the parse state and both valid flags. Only a last byte waits
// on a full output register; other bytes keep flowing while a summary waits.
module ethernet_ip_header_parser_checker_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        frame_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       frame_kind_o,
  output logic [1:0]       l4_kind_o,
  output logic [7:0]       ip_tos_o,
  output logic [7:0]       ip_ttl_o,
  output logic             ip_sum_ok_o,
  output logic [63:0]      ip_pair_o,
  output logic [31:0]      port_pair_o,
  output logic [63:0]      seq_ack_pair_o,
  output logic [2:0]       tcp_flag_bits_o,
  output logic [15:0]      tcp_window_o,
  output logic             tcp_sum_ok_o,
  output logic [15:0]      aux_code_o
);
  import eiphc_pkg::*;

  // Input register.
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       last_q;

  // Parse state.
  logic [15:0] off_q, off_d;
  logic [15:0] etype_q, etype_d;
  logic [3:0]  ver_q, ver_d;
  logic [5:0]  hlen_q, hlen_d;
  logic [15:0] tlen_q, tlen_d;
  logic [7:0]  proto_q, proto_d;
  logic [16:0] ipacc_q, ipacc_d;
  logic [16:0] segacc_q, segacc_d;
  logic [63:0] addr_q, addr_d;
  logic [31:0] ports_q, ports_d;
  logic [63:0] seqack_q, seqack_d;
  logic [7:0]  tos_q, tos_d;
  logic [7:0]  ttl_q, ttl_d;
  logic [15:0] win_q, win_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] arpop_q, arpop_d;
  logic [7:0]  icmp_q, icmp_d;

  logic [15:0] seglen;
  logic [15:0] seg_rel;
  logic [15:0] word;
  logic [15:0] seg_word;
  logic        seg_add;
  logic        fire;
  logic        out_free;
  logic        out_vld_q;
  summary_t    res_d, res_q;

  // A beat leaves the input register unless it closes a frame and the
  // output register still holds an untaken summary.
  assign out_free   = !out_vld_q || out_ready_i;
  assign fire       = in_vld_q && (!last_q || out_free);
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= frame_byte_i;
      last_q <= frame_end_i;
    end
  end

  // Per-byte field capture and checksum accumulation.
  assign seglen  = tlen_q - {10'd0, hlen_q};
  assign seg_rel = off_q - OffL4;
  assign word    = off_q[0] ? {8'd0, byte_q} : {byte_q, 8'd0};

  always_comb begin
    off_d    = off_q;
    etype_d  = etype_q;
    ver_d    = ver_q;
    hlen_d   = hlen_q;
    tlen_d   = tlen_q;
    proto_d  = proto_q;
    ipacc_d  = ipacc_q;
    segacc_d = segacc_q;
    addr_d   = addr_q;
    ports_d  = ports_q;
    seqack_d = seqack_q;
    tos_d    = tos_q;
    ttl_d    = ttl_q;
    win_d    = win_q;
    flags_d  = flags_q;
    arpop_d  = arpop_q;
    icmp_d   = icmp_q;
    seg_add  = 1'b0;
    seg_word = word;

    if (off_q != OffLimit) begin
      off_d = off_q + 16'd1;
      if (off_q == OffEtypeHi || off_q == OffEtypeLo) begin
        etype_d = {etype_q[7:0], byte_q};
      end
      if (off_q == OffIp) begin
        ver_d  = byte_q[7:4];
        hlen_d = {byte_q[3:0], 2'b00};
      end
      if (off_q == OffTos) begin
        tos_d = byte_q;
      end
      if (off_q == OffTlenHi || off_q == OffTlenLo) begin
        tlen_d = {tlen_q[7:0], byte_q};
      end
      if (off_q == OffArpOpHi || off_q == OffArpOpLo) begin
        arpop_d = {arpop_q[7:0], byte_q};
      end
      if (off_q == OffTtl) begin
        ttl_d = byte_q;
      end
      if (off_q == OffProto) begin
        proto_d = byte_q;
      end
      if (off_q >= OffSegStart && off_q < OffL4) begin
        addr_d = {addr_q[55:0], byte_q};
      end
      if (off_q >= OffL4 && off_q < OffPortsEnd) begin
        ports_d = {ports_q[23:0], byte_q};
      end
      if (off_q >= OffPortsEnd && off_q < OffSeqEnd) begin
        seqack_d = {seqack_q[55:0], byte_q};
      end
      if (off_q == OffL4) begin
        icmp_d = byte_q;
      end
      if (off_q == OffFlags) begin
        flags_d = byte_q;
      end
      if (off_q == OffWinHi || off_q == OffWinLo) begin
        win_d = {win_q[7:0], byte_q};
      end

      // IP header words, with the carry out of bit 15 folded in one beat later.
      if (off_q >= OffIp && off_q < OffL4) begin
        ipacc_d = {1'b0, ipacc_q[15:0]} + {16'd0, ipacc_q[16]} + {1'b0, word};
      end

      // The pseudo-header length and protocol enter the segment sum while the
      // gap before the addresses passes; the length is settled by then.
      if (off_q == OffPseudoLen) begin
        seg_add  = 1'b1;
        seg_word = seglen;
      end else if (off_q == OffPseudoPrt) begin
        seg_add  = 1'b1;
        seg_word = {8'd0, ProtoTcp};
      end else if (off_q >= OffSegStart && (off_q < OffL4 || seg_rel < seglen)) begin
        seg_add = 1'b1;
      end
      if (seg_add) begin
        segacc_d = {1'b0, segacc_q[15:0]} + {16'd0, segacc_q[16]} + {1'b0, seg_word};
      end
    end
  end

  // Summary built from the state as it stands after the closing byte.
  always_comb begin
    res_d = '0;
    if (etype_d == EtypeIpv4) begin
      res_d.frame_kind = FK_IPV4;
      res_d.ip_tos     = tos_d;
      res_d.ip_ttl     = ttl_d;
      res_d.ip_sum_ok  = (ipacc_d == SumGoodLo) || (ipacc_d == SumGoodHi);
      res_d.ip_pair    = addr_d;
      if (proto_d == ProtoUdp) begin
        res_d.l4_kind   = L4_UDP;
        res_d.port_pair = ports_d;
      end else if (proto_d == ProtoTcp) begin
        res_d.l4_kind       = L4_TCP;
        res_d.port_pair     = ports_d;
        res_d.seq_ack_pair  = seqack_d;
        res_d.tcp_flag_bits = {flags_d[1], flags_d[2], flags_d[0]};
        res_d.tcp_window    = win_d;
        res_d.tcp_sum_ok    = (segacc_d == SumGoodLo) || (segacc_d == SumGoodHi);
      end else if (proto_d == ProtoIcmp) begin
        res_d.l4_kind = L4_ICMP;
        if (ver_d == IpVersion4) begin
          res_d.aux_code = {8'd0, icmp_d};
        end
      end
    end else if (etype_d == EtypeArp) begin
      res_d.frame_kind = FK_ARP;
      res_d.aux_code   = arpop_d;
    end
  end

  // State registers; a frame's last byte leaves everything cleared.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q    <= '0;
      etype_q  <= '0;
      ver_q    <= '0;
      hlen_q   <= '0;
      tlen_q   <= '0;
      proto_q  <= '0;
      ipacc_q  <= '0;
      segacc_q <= '0;
      addr_q   <= '0;
      ports_q  <= '0;
      seqack_q <= '0;
      tos_q    <= '0;
      ttl_q    <= '0;
      win_q    <= '0;
      flags_q  <= '0;
      arpop_q  <= '0;
      icmp_q   <= '0;
    end else if (fire) begin
      if (last_q) begin
        off_q    <= '0;
        etype_q  <= '0;
        ver_q    <= '0;
        hlen_q   <= '0;
        tlen_q   <= '0;
        proto_q  <= '0;
        ipacc_q  <= '0;
        segacc_q <= '0;
        addr_q   <= '0;
        ports_q  <= '0;
        seqack_q <= '0;
        tos_q    <= '0;
        ttl_q    <= '0;
        win_q    <= '0;
        flags_q  <= '0;
        arpop_q  <= '0;
        icmp_q   <= '0;
      end else begin
        off_q    <= off_d;
        etype_q  <= etype_d;
        ver_q    <= ver_d;
        hlen_q   <= hlen_d;
        tlen_q   <= tlen_d;
        proto_q  <= proto_d;
        ipacc_q  <= ipacc_d;
        segacc_q <= segacc_d;
        addr_q   <= addr_d;
        ports_q  <= ports_d;
        seqack_q <= seqack_d;
        tos_q    <= tos_d;
        ttl_q    <= ttl_d;
        win_q    <= win_d;
        flags_q  <= flags_d;
        arpop_q  <= arpop_d;
        icmp_q   <= icmp_d;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire && last_q) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && last_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign frame_kind_o    = res_q.frame_kind;
  assign l4_kind_o       = res_q.l4_kind;
  assign ip_tos_o        = res_q.ip_tos;
  assign ip_ttl_o        = res_q.ip_ttl;
  assign ip_sum_ok_o     = res_q.ip_sum_ok;
  assign ip_pair_o       = res_q.ip_pair;
  assign port_pair_o     = res_q.port_pair;
  assign seq_ack_pair_o  = res_q.seq_ack_pair;
  assign tcp_flag_bits_o = res_q.tcp_flag_bits;
  assign tcp_window_o    = res_q.tcp_window;
  assign tcp_sum_ok_o    = res_q.tcp_sum_ok;
  assign aux_code_o      = res_q.aux_code;

endmodule

`default_nettype wire

// ===== tb/frame_summary_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the header parser, predicts the summary of every
// frame from the bytes it accepts, and compares each summary beat with it.
module frame_summary_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [7:0]  frame_byte_i,
  input  wire logic        frame_end_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [1:0]  frame_kind_i,
  input  wire logic [1:0]  l4_kind_i,
  input  wire logic [7:0]  ip_tos_i,
  input  wire logic [7:0]  ip_ttl_i,
  input  wire logic        ip_sum_ok_i,
  input  wire logic [63:0] ip_pair_i,
  input  wire logic [31:0] port_pair_i,
  input  wire logic [63:0] seq_ack_pair_i,
  input  wire logic [2:0]  tcp_flag_bits_i,
  input  wire logic [15:0] tcp_window_i,
  input  wire logic        tcp_sum_ok_i,
  input  wire logic [15:0] aux_code_i,
  output logic [31:0]      error_count_o,
  output logic [31:0]      pending_o
);
  import eiphc_pkg::*;

  // A fully folded one's complement sum that verifies.
  localparam logic [15:0] FoldedOnes = 16'hffff;

  // Parse state of the frame in progress.
  logic [15:0] pos;
  logic [15:0] etype;
  logic [3:0]  ver;
  logic [5:0]  hlen;
  logic [15:0] tlen;
  logic [7:0]  proto;
  logic [19:0] hdr_sum;
  logic [31:0] seg_sum;
  logic [63:0] addr_sr;
  logic [31:0] port_sr;
  logic [63:0] seqack_sr;
  logic [7:0]  tos;
  logic [7:0]  ttl;
  logic [7:0]  flags;
  logic [7:0]  icmp_byte;
  logic [15:0] win_sr;
  logic [15:0] arp_op_sr;

  summary_t due_q[$];
  int       errors = 0;
  int       open_frames = 0;

  assign error_count_o = errors;
  assign pending_o     = open_frames;

  function automatic logic [15:0] fold_carries(input logic [31:0] s);
    while (s[31:16] != 16'd0) s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
    return s[15:0];
  endfunction

  function automatic void clear_parse();
    pos       = '0;
    etype     = '0;
    ver       = '0;
    hlen      = '0;
    tlen      = '0;
    proto     = '0;
    hdr_sum   = '0;
    seg_sum   = '0;
    addr_sr   = '0;
    port_sr   = '0;
    seqack_sr = '0;
    tos       = '0;
    ttl       = '0;
    flags     = '0;
    icmp_byte = '0;
    win_sr    = '0;
    arp_op_sr = '0;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    summary_t    want;
    logic [15:0] seglen;
    logic [31:0] word;
    logic [7:0]  b;
    if (!rst_ni) begin
      clear_parse();
      due_q.delete();
      open_frames = 0;
    end else begin
      // A summary beat belongs to a frame whose last byte came earlier.
      if (out_valid_i && out_ready_i) begin
        if (due_q.size() == 0) begin
          $display("%0t: summary beat with no frame pending, actual kind %h",
                   $time, frame_kind_i);
          errors++;
        end else begin
          want = due_q.pop_front();
          open_frames--;
          check_field("frame_kind", 64'(want.frame_kind), 64'(frame_kind_i));
          check_field("l4_kind", 64'(want.l4_kind), 64'(l4_kind_i));
          check_field("ip_tos", 64'(want.ip_tos), 64'(ip_tos_i));
          check_field("ip_ttl", 64'(want.ip_ttl), 64'(ip_ttl_i));
          check_field("ip_sum_ok", 64'(want.ip_sum_ok), 64'(ip_sum_ok_i));
          check_field("ip_pair", want.ip_pair, ip_pair_i);
          check_field("port_pair", 64'(want.port_pair), 64'(port_pair_i));
          check_field("seq_ack_pair", want.seq_ack_pair, seq_ack_pair_i);
          check_field("tcp_flag_bits", 64'(want.tcp_flag_bits), 64'(tcp_flag_bits_i));
          check_field("tcp_window", 64'(want.tcp_window), 64'(tcp_window_i));
          check_field("tcp_sum_ok", 64'(want.tcp_sum_ok), 64'(tcp_sum_ok_i));
          check_field("aux_code", 64'(want.aux_code), 64'(aux_code_i));
        end
      end

      // A byte beat updates the parse state unless the offset has saturated.
      if (in_valid_i && in_ready_i) begin
        b      = frame_byte_i;
        seglen = tlen - {10'd0, hlen};
        word   = pos[0] ? {24'd0, b} : {16'd0, b, 8'd0};
        if (pos != OffLimit) begin
          if (pos == OffEtypeHi || pos == OffEtypeLo) etype = {etype[7:0], b};
          if (pos == OffIp) begin
            ver  = b[7:4];
            hlen = {b[3:0], 2'b00};
          end
          if (pos == OffTos) tos = b;
          if (pos == OffTlenHi || pos == OffTlenLo) tlen = {tlen[7:0], b};
          if (pos == OffArpOpHi || pos == OffArpOpLo) arp_op_sr = {arp_op_sr[7:0], b};
          if (pos == OffTtl) ttl = b;
          if (pos == OffProto) proto = b;
          if (pos >= OffSegStart && pos < OffL4) addr_sr = {addr_sr[55:0], b};
          if (pos >= OffL4 && pos < OffPortsEnd) port_sr = {port_sr[23:0], b};
          if (pos >= OffPortsEnd && pos < OffSeqEnd) seqack_sr = {seqack_sr[55:0], b};
          if (pos == OffL4) icmp_byte = b;
          if (pos == OffFlags) flags = b;
          if (pos == OffWinHi || pos == OffWinLo) win_sr = {win_sr[7:0], b};
          // Header words, then pseudo-header addresses and the segment proper;
          // link padding past the segment length is left out.
          if (pos >= OffIp && pos < OffL4) hdr_sum = hdr_sum + word[19:0];
          if (pos >= OffSegStart && (pos < OffL4 || (pos - OffL4) < seglen))
            seg_sum = seg_sum + word;
          pos = pos + 16'd1;
        end

        // The last byte closes the frame and queues its summary.
        if (frame_end_i) begin
          seglen = tlen - {10'd0, hlen};
          want   = '0;
          if (etype == EtypeIpv4) begin
            want.frame_kind = FK_IPV4;
            want.ip_tos     = tos;
            want.ip_ttl     = ttl;
            want.ip_sum_ok  = (fold_carries({12'd0, hdr_sum}) == FoldedOnes);
            want.ip_pair    = addr_sr;
            if (proto == ProtoUdp) begin
              want.l4_kind   = L4_UDP;
              want.port_pair = port_sr;
            end else if (proto == ProtoTcp) begin
              want.l4_kind       = L4_TCP;
              want.port_pair     = port_sr;
              want.seq_ack_pair  = seqack_sr;
              want.tcp_flag_bits = {flags[1], flags[2], flags[0]};
              want.tcp_window    = win_sr;
              want.tcp_sum_ok    = (fold_carries({16'd0, fold_carries(seg_sum)}
                                    + {24'd0, ProtoTcp} + {16'd0, seglen}) == FoldedOnes);
            end else if (proto == ProtoIcmp) begin
              want.l4_kind = L4_ICMP;
              if (ver == IpVersion4) want.aux_code = {8'd0, icmp_byte};
            end
          end else if (etype == EtypeArp) begin
            want.frame_kind = FK_ARP;
            want.aux_code   = arp_op_sr;
          end
          due_q.push_back(want);
          open_frames++;
          clear_parse();
        end
      end
    end
  end

endmodule

// ===== tb/ethernet_ip_header_parser_checker_top_test.sv =====
`timescale 1ns / 1ps

module ethernet_ip_header_parser_checker_top_test;
  import eiphc_pkg::*;

  localparam int QuietLimit = 4000;
  localparam int LongHold   = 250;
  localparam int DrainWait  = 10;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [7:0]  frame_byte = 8'd0;
  logic        frame_end  = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [1:0]  frame_kind;
  logic [1:0]  l4_kind;
  logic [7:0]  ip_tos;
  logic [7:0]  ip_ttl;
  logic        ip_sum_ok;
  logic [63:0] ip_pair;
  logic [31:0] port_pair;
  logic [63:0] seq_ack_pair;
  logic [2:0]  tcp_flag_bits;
  logic [15:0] tcp_window;
  logic        tcp_sum_ok;
  logic [15:0] aux_code;

  logic [31:0] mismatches;
  logic [31:0] pending;

  // Stimulus controls shared with the receiver.
  bit          idle_on   = 1'b1;
  int unsigned hold_req  = 0;
  int unsigned hold_seen = 0;
  int          quiet     = 0;
  int          bytes_sent  = 0;

  logic [7:0] frame_q[$];

  always #10 clk_i = ~clk_i;

  ethernet_ip_header_parser_checker_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .frame_byte_i   (frame_byte),
    .frame_end_i    (frame_end),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .frame_kind_o   (frame_kind),
    .l4_kind_o      (l4_kind),
    .ip_tos_o       (ip_tos),
    .ip_ttl_o       (ip_ttl),
    .ip_sum_ok_o    (ip_sum_ok),
    .ip_pair_o      (ip_pair),
    .port_pair_o    (port_pair),
    .seq_ack_pair_o (seq_ack_pair),
    .tcp_flag_bits_o(tcp_flag_bits),
    .tcp_window_o   (tcp_window),
    .tcp_sum_ok_o   (tcp_sum_ok),
    .aux_code_o     (aux_code)
  );

  frame_summary_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .frame_byte_i   (frame_byte),
    .frame_end_i    (frame_end),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .frame_kind_i   (frame_kind),
    .l4_kind_i      (l4_kind),
    .ip_tos_i       (ip_tos),
    .ip_ttl_i       (ip_ttl),
    .ip_sum_ok_i    (ip_sum_ok),
    .ip_pair_i      (ip_pair),
    .port_pair_i    (port_pair),
    .seq_ack_pair_i (seq_ack_pair),
    .tcp_flag_bits_i(tcp_flag_bits),
    .tcp_window_i   (tcp_window),
    .tcp_sum_ok_i   (tcp_sum_ok),
    .aux_code_i     (aux_code),
    .error_count_o  (mismatches),
    .pending_o      (pending)
  );

  // Watchdog: too many cycles in a row without any beat ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Summary receiver: random stall bursts, and a long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_ready <= 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk_i);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void fill_frame(input int len, input int pattern);
    frame_q.delete();
    for (int i = 0; i < len; i++)
      frame_q.push_back(pattern < 0 ? 8'($urandom) : 8'(pattern));
  endfunction

  function automatic void set_word(input int at, input logic [15:0] w);
    frame_q[at]     = w[15:8];
    frame_q[at + 1] = w[7:0];
  endfunction

  function automatic void cut_frame(input int len);
    while (frame_q.size() > len) void'(frame_q.pop_back());
  endfunction

  // Checksum that makes the word sum over [from, upto) plus extra fold to ones.
  function automatic logic [15:0] ones_sum_inv(input int from, input int upto,
                                               input logic [31:0] extra);
    logic [31:0] acc;
    acc = extra;
    for (int o = from; o < upto; o++)
      acc = acc + ((o % 2) ? {24'd0, frame_q[o]} : {16'd0, frame_q[o], 8'd0});
    while (acc[31:16] != 16'd0) acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
    return ~acc[15:0];
  endfunction

  // IPv4 frame with layer 4 at the fixed offset and seglen segment bytes.
  function automatic void build_ipv4(input logic [7:0] proto, input logic [3:0] ver,
                                     input logic [3:0] ihl, input int seglen,
                                     input int pad, input int pattern,
                                     input bit good_ip, input bit good_tcp);
    fill_frame(34 + seglen + pad, pattern);
    set_word(12, EtypeIpv4);
    frame_q[14] = {ver, ihl};
    set_word(16, 16'(seglen + ihl * 4));
    frame_q[23] = proto;
    set_word(24, 16'd0);
    if (proto == ProtoTcp && seglen >= 18) begin
      set_word(50, 16'd0);
      set_word(50, ones_sum_inv(26, 34 + seglen, 32'(ProtoTcp) + 32'(seglen)));
      if (!good_tcp) frame_q[51] = frame_q[51] ^ 8'($urandom_range(1, 255));
    end
    set_word(24, ones_sum_inv(14, 34, 32'd0));
    if (!good_ip) frame_q[24] = frame_q[24] ^ 8'($urandom_range(1, 255));
  endfunction

  // Offers one byte beat, with an optional gap before it.
  task automatic send_beat(input logic [7:0] b, input logic lst);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid   <= 1'b1;
    frame_byte <= b;
    frame_end  <= lst;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_beat(frame_q[i], i == frame_q.size() - 1);
    bytes_sent += frame_q.size();
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (pending == 0);
  endtask

  // Mostly well-formed frames with random content, plus broken ones and noise.
  task automatic send_random_frame();
    int         pick;
    int         seglen;
    int         pad;
    logic [3:0] ihl;
    logic [3:0] ver;
    pick   = $urandom_range(0, 99);
    seglen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : $urandom_range(20, 60);
    pad    = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
    ihl    = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd5;
    ver    = ($urandom_range(0, 9) == 0) ? 4'($urandom) : IpVersion4;
    if (pick < 45) begin
      build_ipv4(ProtoTcp, ver, ihl, seglen, pad, -1,
                 $urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0);
    end else if (pick < 57) begin
      build_ipv4(ProtoUdp, ver, ihl, seglen, pad, -1, $urandom_range(0, 9) != 0, 1'b1);
    end else if (pick < 65) begin
      build_ipv4(ProtoIcmp, $urandom_range(0, 1) ? IpVersion4 : 4'($urandom), ihl,
                 seglen, pad, -1, 1'b1, 1'b1);
    end else if (pick < 70) begin
      build_ipv4(8'($urandom), ver, ihl, seglen, pad, -1, 1'b1, 1'b1);
    end else if (pick < 80) begin
      fill_frame($urandom_range(22, 60), -1);
      set_word(12, EtypeArp);
      set_word(20, $urandom_range(0, 1) ? 16'($urandom_range(1, 2)) : 16'($urandom));
    end else if (pick < 85) begin
      fill_frame($urandom_range(14, 70), -1);
    end else if (pick < 93) begin
      build_ipv4($urandom_range(0, 1) ? ProtoTcp : ProtoUdp, ver, ihl, seglen, pad, -1,
                 1'b1, 1'b1);
      cut_frame($urandom_range(1, frame_q.size()));
    end else begin
      fill_frame($urandom_range(1, 80), -1);
    end
    send_frame();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames: extremes, every frame and protocol kind, short frames.
    fill_frame(1, -1);
    send_frame();
    fill_frame(13, -1);
    frame_q[12] = 8'h08;
    send_frame();
    build_ipv4(ProtoTcp, IpVersion4, 4'd15, 20, 0, 8'hff, 1'b1, 1'b1);
    send_frame();
    build_ipv4(ProtoTcp, IpVersion4, 4'd5, 20, 0, 8'h00, 1'b1, 1'b1);
    send_frame();
    // Empty sums: an IPv4 TCP frame that is zero apart from the type codes.
    fill_frame(40, 8'h00);
    set_word(12, EtypeIpv4);
    frame_q[23] = ProtoTcp;
    send_frame();
    // Segment lengths odd and even, with and without link padding, and bad sums.
    build_ipv4(ProtoTcp, IpVersion4, 4'd5, 21, 0, -1, 1'b1, 1'b1);
    send_frame();
    build_ipv4(ProtoTcp, IpVersion4, 4'd5, 23, 7, -1, 1'b1, 1'b1);
    send_frame();
    build_ipv4(ProtoTcp, IpVersion4, 4'd5, 30, 2, -1, 1'b0, 1'b0);
    send_frame();
    // Total length below the header length wraps the segment length.
    build_ipv4(ProtoTcp, IpVersion4, 4'd5, 20, 0, -1, 1'b1, 1'b1);
    set_word(16, 16'd4);
    send_frame();
    build_ipv4(ProtoTcp, IpVersion4, 4'd0, 30, 0, -1, 1'b1, 1'b1);
    send_frame();
    build_ipv4(ProtoUdp, IpVersion4, 4'd5, 12, 4, -1, 1'b1, 1'b1);
    send_frame();
    build_ipv4(ProtoIcmp, IpVersion4, 4'd5, 8, 0, -1, 1'b1, 1'b1);
    send_frame();
    build_ipv4(ProtoIcmp, 4'd6, 4'd5, 8, 0, -1, 1'b1, 1'b1);
    send_frame();
    build_ipv4(8'h2f, IpVersion4, 4'd5, 10, 0, -1, 1'b1, 1'b1);
    send_frame();
    fill_frame(42, -1);
    set_word(12, EtypeArp);
    set_word(20, 16'd1);
    send_frame();
    fill_frame(60, 8'hff);
    set_word(12, EtypeArp);
    send_frame();
    fill_frame(28, 8'h00);
    set_word(12, EtypeArp);
    set_word(20, 16'd2);
    send_frame();
    fill_frame(60, -1);
    set_word(12, 16'h86dd);
    send_frame();
    // Frames cut inside the total length field and inside the window field.
    build_ipv4(ProtoTcp, IpVersion4, 4'd5, 20, 0, -1, 1'b1, 1'b1);
    cut_frame(17);
    send_frame();
    build_ipv4(ProtoTcp, IpVersion4, 4'd5, 20, 0, -1, 1'b1, 1'b1);
    cut_frame(49);
    send_frame();
    pause_until_drained();

    // Back-pressure: the receiver holds off while short frames keep coming.
    idle_on = 1'b0;
    hold_req++;
    for (int i = 0; i < 4; i++) begin
      fill_frame(14, -1);
      set_word(12, 16'h88b5);
      send_frame();
    end
    pause_until_drained();

    // Random traffic, then a final stretch without gaps on either side.
    while (bytes_sent < 1100) begin
      idle_on = ($urandom_range(0, 3) != 0);
      send_random_frame();
      if ($urandom_range(0, 19) == 0) pause_until_drained();
    end
    idle_on = 1'b0;
    for (int i = 0; i < 3; i++) send_random_frame();
    pause_until_drained();
    repeat (DrainWait) @(posedge clk_i);

    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
